FILE: rtl/dfcw_pkg.sv
package dfcw_pkg;

  // Reciprocal of the frequency step, unsigned Q8.32
  localparam logic [63:0] RECIP_Q8_32 = 64'd368934881560;
  localparam logic [7:0]  RECIP_HI    = RECIP_Q8_32[39:32];
  localparam logic [31:0] RECIP_LO    = RECIP_Q8_32[31:0];

  // Tuning word for the start-up frequency, worked out at elaboration
  localparam logic [63:0] INIT_FREQ_HZ = 64'd500;
  localparam logic [63:0] INIT_PROD    = INIT_FREQ_HZ * RECIP_Q8_32;
  localparam logic [31:0] INIT_TW      = INIT_PROD[63:32];

  // Product width: f * hi plus the high half of f * lo
  localparam int WORD_W = 40;

  // Opcodes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_INIT = 1'b1;

  // Sequence lengths, as the index of the final word
  localparam logic [3:0] SET_LAST  = 4'd3;
  localparam logic [3:0] INIT_LAST = 4'd10;

  // Request queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command codes
  localparam logic [15:0] CMD_DEFER_WR    = 16'h3000;
  localparam logic [15:0] CMD_WR          = 16'h2000;
  localparam logic [15:0] CMD_SLEEP_RST   = 16'hF800;
  localparam logic [15:0] CMD_SYNC_SEL    = 16'hB000;
  localparam logic [15:0] CMD_PHASE0_LO   = 16'h1800;
  localparam logic [15:0] CMD_PHASE0_HI   = 16'h0900;
  localparam logic [15:0] CMD_SEL_FREQ    = 16'h5000;
  localparam logic [15:0] CMD_SEL_PHASE   = 16'h4000;
  localparam logic [15:0] CMD_WAKE        = 16'hC000;

  // Initialization word positions
  localparam logic [3:0] IDX_SLEEP_RST = 4'd0;
  localparam logic [3:0] IDX_SYNC_SEL  = 4'd1;
  localparam logic [3:0] IDX_FREQ_B0   = 4'd2;
  localparam logic [3:0] IDX_FREQ_B1   = 4'd3;
  localparam logic [3:0] IDX_FREQ_B2   = 4'd4;
  localparam logic [3:0] IDX_FREQ_B3   = 4'd5;
  localparam logic [3:0] IDX_PHASE_LO  = 4'd6;
  localparam logic [3:0] IDX_PHASE_HI  = 4'd7;
  localparam logic [3:0] IDX_SEL_FREQ  = 4'd8;
  localparam logic [3:0] IDX_SEL_PHASE = 4'd9;
  localparam logic [3:0] IDX_WAKE      = 4'd10;

  // Converted request, front to back
  typedef struct packed {
    logic        opcode;
    logic [31:0] tw;
    logic        sat;
  } dfcw_req_t;

  // Byte k of frequency register 0: even bytes deferred, odd bytes commit
  function automatic logic [15:0] byte_cmd(input logic [31:0] tw, input logic [1:0] k);
    logic [15:0] base;
    logic [7:0]  b;
    base = k[0] ? CMD_WR : CMD_DEFER_WR;
    case (k)
      2'd0:    b = tw[7:0];
      2'd1:    b = tw[15:8];
      2'd2:    b = tw[23:16];
      default: b = tw[31:24];
    endcase
    return base | {6'b0, k, b};
  endfunction

  // Start-up sequence word at a given index
  function automatic logic [15:0] init_cmd(input logic [3:0] idx);
    logic [15:0] w;
    case (idx)
      IDX_SLEEP_RST: w = CMD_SLEEP_RST;
      IDX_SYNC_SEL:  w = CMD_SYNC_SEL;
      IDX_FREQ_B0:   w = byte_cmd(INIT_TW, 2'd0);
      IDX_FREQ_B1:   w = byte_cmd(INIT_TW, 2'd1);
      IDX_FREQ_B2:   w = byte_cmd(INIT_TW, 2'd2);
      IDX_FREQ_B3:   w = byte_cmd(INIT_TW, 2'd3);
      IDX_PHASE_LO:  w = CMD_PHASE0_LO;
      IDX_PHASE_HI:  w = CMD_PHASE0_HI;
      IDX_SEL_FREQ:  w = CMD_SEL_FREQ;
      IDX_SEL_PHASE: w = CMD_SEL_PHASE;
      default:       w = CMD_WAKE;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/dfcw_front.sv
module dfcw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [31:0]                    in_freq_hz,
  input  logic [dfcw_pkg::Q_CNT_W-1:0]   q_count,
  output logic                           push,
  output dfcw_pkg::dfcw_req_t            push_req
);

  logic        v1_r, v1_nxt;
  logic        v2_r, v2_nxt;
  logic        op1_r;
  logic [31:0] f1_r;
  logic [63:0] prod_lo_r;
  dfcw_pkg::dfcw_req_t req_r;

  logic [dfcw_pkg::Q_CNT_W-1:0]  used;
  logic [dfcw_pkg::WORD_W-1:0]   word;
  logic                          accept;

  // Credit check: queued plus in-flight requests must leave a free slot
  assign used   = q_count + dfcw_pkg::Q_CNT_W'(v1_r) + dfcw_pkg::Q_CNT_W'(v2_r);
  assign busy   = (used >= dfcw_pkg::Q_CNT_W'(dfcw_pkg::Q_DEPTH));
  assign accept = start && !busy;

  assign v1_nxt = accept;
  assign v2_nxt = v1_r;

  // Second stage: integer part of f * R, saturate above 32 bits
  assign word = dfcw_pkg::WORD_W'(f1_r) * dfcw_pkg::WORD_W'(dfcw_pkg::RECIP_HI)
              + dfcw_pkg::WORD_W'(prod_lo_r[63:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // First stage: fraction product
  always_ff @(posedge clk) begin
    if (accept) begin
      op1_r     <= in_opcode;
      f1_r      <= in_freq_hz;
      prod_lo_r <= 64'(in_freq_hz) * 64'(dfcw_pkg::RECIP_LO);
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      req_r.opcode <= op1_r;
      req_r.sat    <= |word[dfcw_pkg::WORD_W-1:32];
      req_r.tw     <= (|word[dfcw_pkg::WORD_W-1:32]) ? 32'hFFFF_FFFF : word[31:0];
    end
  end

  assign push     = v2_r;
  assign push_req = req_r;

endmodule

FILE: rtl/dfcw_fifo.sv
module dfcw_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  dfcw_pkg::dfcw_req_t            wdata,
  input  logic                           pop,
  output dfcw_pkg::dfcw_req_t            rdata,
  output logic                           empty,
  output logic [dfcw_pkg::Q_CNT_W-1:0]   count
);

  dfcw_pkg::dfcw_req_t mem_r [dfcw_pkg::Q_DEPTH];

  logic [dfcw_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dfcw_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dfcw_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign wr_ptr_nxt = push ? wr_ptr_r + dfcw_pkg::Q_PTR_W'(1) : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + dfcw_pkg::Q_PTR_W'(1) : rd_ptr_r;
  assign cnt_nxt    = cnt_r + dfcw_pkg::Q_CNT_W'(push) - dfcw_pkg::Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage; front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

FILE: rtl/dfcw_back.sv
module dfcw_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  dfcw_pkg::dfcw_req_t     q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [15:0]             out_command_word,
  output logic [3:0]              out_word_index,
  output logic                    out_last,
  output logic                    out_saturated
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t          state_r, state_nxt;
  logic [3:0]          idx_r, idx_nxt;
  dfcw_pkg::dfcw_req_t cur_r;

  logic at_last;
  logic load;

  assign at_last = (cur_r.opcode == dfcw_pkg::OP_SET) ? (idx_r == dfcw_pkg::SET_LAST)
                                                       : (idx_r == dfcw_pkg::INIT_LAST);

  // Take the next request when idle or on the final word of the current one
  assign load  = ((state_r == ST_IDLE) || at_last) && !q_empty;
  assign q_pop = load;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_RUN;
          idx_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (load) begin
          idx_nxt = '0;
        end else if (at_last) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_rdata;
    end
  end

  // Word select
  assign out_valid        = (state_r == ST_RUN);
  assign out_command_word = (cur_r.opcode == dfcw_pkg::OP_SET)
                          ? dfcw_pkg::byte_cmd(cur_r.tw, idx_r[1:0])
                          : dfcw_pkg::init_cmd(idx_r);
  assign out_word_index   = idx_r;
  assign out_last         = at_last;
  assign out_saturated    = (cur_r.opcode == dfcw_pkg::OP_SET) && cur_r.sat;

endmodule

FILE: rtl/dds_frequency_command_writer.sv
// Channel  Ports                                                        Handshake
// input    in_opcode, in_freq_hz                                        start & !busy
// result   out_command_word, out_word_index, out_last, out_saturated    out_valid, one cycle
//
// One command word per cycle: a set-frequency request gives 4 words on the
// output, initialization 11; the output sequencer sets that rate.
// A two-stage multiply pipeline and a four-entry queue sit ahead of it, so a
// taken request passes both multiply stages and the queue before its first word.
// busy rises when queued plus in-flight requests fill the queue; reset (synchronous,
// active low) empties pipeline and queue. The receiver cannot stall.
module dds_frequency_command_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_freq_hz,
  output logic        out_valid,
  output logic [15:0] out_command_word,
  output logic [3:0]  out_word_index,
  output logic        out_last,
  output logic        out_saturated
);

  logic                          push;
  dfcw_pkg::dfcw_req_t           push_req;
  logic                          pop;
  dfcw_pkg::dfcw_req_t           q_rdata;
  logic                          q_empty;
  logic [dfcw_pkg::Q_CNT_W-1:0]  q_count;

  // Request intake and tuning word conversion
  dfcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_freq_hz (in_freq_hz),
    .q_count    (q_count),
    .push       (push),
    .push_req   (push_req)
  );

  // Request queue
  dfcw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_req),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  // Command word sequencer
  dfcw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_command_word (out_command_word),
    .out_word_index   (out_word_index),
    .out_last         (out_last),
    .out_saturated    (out_saturated)
  );

endmodule

FILE: tb/sv/dds_frequency_command_writer_tb.sv
`timescale 1ns / 1ps

module dds_frequency_command_writer_tb;
  localparam logic OP_SET  = dfcw_pkg::OP_SET;
  localparam logic OP_INIT = dfcw_pkg::OP_INIT;

  // Reciprocal of the frequency step, unsigned Q8.32
  localparam logic [71:0] HZ_TO_TW_RECIP = 72'd368934881560;
  localparam logic [31:0] STARTUP_HZ     = 32'd500;

  // Command codes
  localparam logic [15:0] DEFER_WR_CMD    = 16'h3000;
  localparam logic [15:0] WR_CMD          = 16'h2000;
  localparam logic [15:0] SLEEP_RESET_CMD = 16'hF800;
  localparam logic [15:0] SYNC_SRC_CMD    = 16'hB000;
  localparam logic [15:0] PHASE0_LO_CMD   = 16'h1800;
  localparam logic [15:0] PHASE0_HI_CMD   = 16'h0900;
  localparam logic [15:0] SEL_FREQ_CMD    = 16'h5000;
  localparam logic [15:0] SEL_PHASE_CMD   = 16'h4000;
  localparam logic [15:0] WAKE_CMD        = 16'hC000;

  localparam int SET_WORDS     = 4;
  localparam int INIT_WORDS    = 11;
  localparam int RANDOM_ITEMS  = 77;
  localparam int IDLE_LIMIT    = 1000;
  localparam int TAIL_CYCLES   = 12;
  // Saturation sets in at 50 MHz; one hertz below still fits
  localparam logic [31:0] SAT_EDGE_HZ = 32'd50_000_000;

  typedef struct packed {
    logic [15:0] cmd;
    logic [3:0]  idx;
    logic        last;
    logic        sat;
  } cmd_word_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [31:0] in_freq_hz;
  logic        out_valid;
  logic [15:0] out_command_word;
  logic [3:0]  out_word_index;
  logic        out_last;
  logic        out_saturated;

  cmd_word_t pending_words[$];
  int        errors;
  int        words_checked;
  int        set_requests;
  int        init_requests;
  int        clamped_requests;

  dds_frequency_command_writer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_freq_hz       (in_freq_hz),
    .out_valid        (out_valid),
    .out_command_word (out_command_word),
    .out_word_index   (out_word_index),
    .out_last         (out_last),
    .out_saturated    (out_saturated)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Tuning word: floor(f * R / 2^32), clamped to 32 bits
  function automatic logic [31:0] hz_to_tuning_word(input logic [31:0] hz,
                                                    output logic clamped);
    logic [71:0] prod;
    prod = {40'd0, hz} * HZ_TO_TW_RECIP;
    clamped = |prod[71:64];
    return clamped ? 32'hFFFF_FFFF : prod[63:32];
  endfunction

  // Byte k of frequency register 0
  function automatic logic [15:0] freq_byte_cmd(input logic [31:0] tw, input int k);
    logic [15:0] base;
    logic [7:0]  b;
    base = (k % 2) ? WR_CMD : DEFER_WR_CMD;
    b = tw[8*k +: 8];
    return base | (16'(k) << 8) | {8'd0, b};
  endfunction

  // Expected command words for one accepted request
  task automatic predict_commands(input logic op, input logic [31:0] hz);
    logic        clamped;
    logic [31:0] tw;
    logic [15:0] seq[INIT_WORDS];
    cmd_word_t   w;
    if (op == OP_SET) begin
      tw = hz_to_tuning_word(hz, clamped);
      set_requests++;
      if (clamped) clamped_requests++;
      for (int k = 0; k < SET_WORDS; k++) begin
        w.cmd  = freq_byte_cmd(tw, k);
        w.idx  = 4'(k);
        w.last = (k == SET_WORDS - 1);
        w.sat  = clamped;
        pending_words.push_back(w);
      end
    end else begin
      tw = hz_to_tuning_word(STARTUP_HZ, clamped);
      init_requests++;
      seq[0]  = SLEEP_RESET_CMD;
      seq[1]  = SYNC_SRC_CMD;
      for (int k = 0; k < SET_WORDS; k++) seq[2 + k] = freq_byte_cmd(tw, k);
      seq[6]  = PHASE0_LO_CMD;
      seq[7]  = PHASE0_HI_CMD;
      seq[8]  = SEL_FREQ_CMD;
      seq[9]  = SEL_PHASE_CMD;
      seq[10] = WAKE_CMD;
      for (int k = 0; k < INIT_WORDS; k++) begin
        w.cmd  = seq[k];
        w.idx  = 4'(k);
        w.last = (k == INIT_WORDS - 1);
        w.sat  = clamped;
        pending_words.push_back(w);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    cmd_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected command word", out_command_word, 0);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_command_word !== want.cmd)
          report_mismatch("command_word", out_command_word, want.cmd);
        if (out_word_index !== want.idx)
          report_mismatch("word_index", out_word_index, want.idx);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", out_saturated, want.sat);
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Present one request and hold it until taken; called and returns at negedge
  task automatic send_request(input logic op, input logic [31:0] hz);
    logic taken;
    taken = 1'b0;
    start = 1'b1;
    in_opcode = op;
    in_freq_hz = hz;
    while (!taken) begin
      @(posedge clk);
      if (!busy) begin
        predict_commands(op, hz);
        taken = 1'b1;
      end
      @(negedge clk);
    end
  endtask

  // Drop start with junk on the fields and idle for the requested gap
  task automatic idle_gap(input int n);
    start = 1'b0;
    in_opcode = 1'($urandom);
    in_freq_hz = $urandom;
    repeat (n) @(negedge clk);
  endtask

  // Hold off until every outstanding word has come out
  task automatic wait_drained();
    start = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Frequency extremes, bit patterns and the clamp boundary
  task automatic test_set_extremes();
    send_request(OP_SET, 32'd0);
    send_request(OP_SET, 32'd1);
    send_request(OP_SET, 32'd500);
    idle_gap(2);
    send_request(OP_SET, 32'h00AA_AAAA);
    send_request(OP_SET, 32'h0055_5555);
    send_request(OP_SET, SAT_EDGE_HZ - 32'd1);
    idle_gap(1);
    send_request(OP_SET, SAT_EDGE_HZ);
    send_request(OP_SET, SAT_EDGE_HZ + 32'd1);
    send_request(OP_SET, 32'hAAAA_AAAA);
    send_request(OP_SET, 32'h5555_5555);
    send_request(OP_SET, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Start-up sequence; the frequency field must not matter
  task automatic test_init_sequence();
    send_request(OP_INIT, 32'd0);
    idle_gap(3);
    send_request(OP_INIT, 32'hFFFF_FFFF);
    send_request(OP_SET, 32'd1_000_000);
    wait_drained();
  endtask

  // Back-to-back requests to fill the queue and exercise busy
  task automatic test_queue_full();
    send_request(OP_INIT, $urandom);
    send_request(OP_INIT, $urandom);
    send_request(OP_SET, 32'd12_345_678);
    send_request(OP_INIT, $urandom);
    send_request(OP_INIT, $urandom);
    send_request(OP_SET, 32'hFFFF_FFFF);
    send_request(OP_SET, 32'd7);
    send_request(OP_INIT, $urandom);
    wait_drained();
  endtask

  function automatic logic [31:0] pick_freq();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return $urandom_range(0, SAT_EDGE_HZ);
      4, 5:       return $urandom;
      6:          return $urandom_range(SAT_EDGE_HZ - 20, SAT_EDGE_HZ + 20);
      7:          return $urandom_range(0, 255);
      default:    return $urandom_range(0, 1_000_000);
    endcase
  endfunction

  // Random bursts of mixed requests with random gaps
  task automatic test_random_traffic();
    int sent;
    int burst;
    int bursts;
    logic op;
    sent = 0;
    bursts = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        op = ($urandom_range(0, 99) < 15) ? OP_INIT : OP_SET;
        send_request(op, pick_freq());
        sent++;
      end
      bursts++;
      if (bursts % 6 == 0) wait_drained();
      else if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    wait_drained();
  endtask

  initial begin
    errors = 0;
    words_checked = 0;
    set_requests = 0;
    init_requests = 0;
    clamped_requests = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_SET;
    in_freq_hz = 32'd0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_set_extremes();
    test_init_sequence();
    test_queue_full();
    test_random_traffic();

    // Let any stray words show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch("words never produced", 0, pending_words.size());

    $display("covered %0d set-frequency requests (%0d clamped), %0d start-up sequences",
             set_requests, clamped_requests, init_requests);
    $display("%0d command words compared, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
